@@ rtl/rbf_pkg.sv @@
// Package for the clamped row box filter: shared constants, the front-to-back
// command item, the back end state type and the reciprocal table.
// Has no dependencies; every other file of the block imports it.
`default_nettype none

package rbf_pkg;

  localparam int unsigned PIX_W       = 8;
  localparam int unsigned RAD_W       = 5;
  localparam int unsigned WID_W       = 13;
  localparam int unsigned SUM_W       = 14;
  localparam int unsigned RCP_W       = 21;
  localparam int unsigned RCP_SHIFT   = 20;
  localparam int unsigned COL_LO_W    = 6;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_ROWS = 2'd2;

  localparam logic [RAD_W-1:0] RADIUS_RESET     = 5'd1;
  localparam logic [WID_W-1:0] ROW_WIDTH_RESET  = 13'd640;
  localparam logic [WID_W-1:0] FRAME_ROWS_RESET = 13'd480;

  localparam logic [COL_LO_W-1:0] COL_SAT_MAX = 6'd63;

  typedef struct packed {
    logic [RAD_W-1:0] radius;
    logic [WID_W-1:0] row_width;
    logic [WID_W-1:0] frame_rows;
  } cfg_t;

  // One classified pixel as handed from the front end to the back end.
  typedef struct packed {
    logic [PIX_W-1:0]    pixel;
    logic [COL_LO_W-1:0] col_lo;   // column modulo 64
    logic [COL_LO_W-1:0] col_sat;  // column saturated at 63
    logic [RAD_W-1:0]    radius;   // radius latched for this row
    logic                row_last;
    logic                frame_last;
  } cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SUM,
    BK_FL_RD,
    BK_FL_UPD,
    BK_MUL,
    BK_OUT
  } back_state_e;

  // ceil(2^20 / (2r+1)); exact floor division for numerators below 2^14.
  function automatic logic [RCP_W-1:0] recip(input logic [RAD_W-1:0] rad);
    logic [RCP_W-1:0] v;
    case (rad)
      5'd0:    v = 21'd1048576;
      5'd1:    v = 21'd349526;
      5'd2:    v = 21'd209716;
      5'd3:    v = 21'd149797;
      5'd4:    v = 21'd116509;
      5'd5:    v = 21'd95326;
      5'd6:    v = 21'd80660;
      5'd7:    v = 21'd69906;
      5'd8:    v = 21'd61681;
      5'd9:    v = 21'd55189;
      5'd10:   v = 21'd49933;
      5'd11:   v = 21'd45591;
      5'd12:   v = 21'd41944;
      5'd13:   v = 21'd38837;
      5'd14:   v = 21'd36158;
      5'd15:   v = 21'd33826;
      5'd16:   v = 21'd31776;
      5'd17:   v = 21'd29960;
      5'd18:   v = 21'd28340;
      5'd19:   v = 21'd26887;
      5'd20:   v = 21'd25576;
      5'd21:   v = 21'd24386;
      5'd22:   v = 21'd23302;
      5'd23:   v = 21'd22311;
      5'd24:   v = 21'd21400;
      5'd25:   v = 21'd20561;
      5'd26:   v = 21'd19785;
      5'd27:   v = 21'd19066;
      5'd28:   v = 21'd18397;
      5'd29:   v = 21'd17773;
      5'd30:   v = 21'd17190;
      5'd31:   v = 21'd16645;
      default: v = 21'd1048576;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

@@ rtl/rbf_pix_if.sv @@
// Pixel input channel of the row box filter: valid, ready and one pixel.
// Depends on rbf_pkg for the pixel width.
`default_nettype none

interface rbf_pix_if;
  import rbf_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

`default_nettype wire

@@ rtl/rbf_res_if.sv @@
// Result channel of the row box filter: valid, ready and one filtered item.
// Depends on rbf_pkg for the pixel width.
`default_nettype none

interface rbf_res_if;
  import rbf_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] blurred;
  logic             row_end;
  logic             frame_end;
  logic             last;

  modport source (output valid, output blurred, output row_end, output frame_end,
                  output last, input ready);
  modport sink   (input valid, input blurred, input row_end, input frame_end,
                  input last, output ready);
endinterface

`default_nettype wire

@@ rtl/rbf_front.sv @@
// Front end of the row box filter: accepts pixels, tracks column and row,
// latches the row radius and pushes classified commands. Uses rbf_pkg, rbf_pix_if.
`default_nettype none

module rbf_front #(
  parameter int unsigned MAX_RADIUS = 31,
  parameter int unsigned MAX_WIDTH  = 4096
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  rbf_pkg::cfg_t cfg_i,
  rbf_pix_if.sink       pix_i,
  input  logic          q_full_i,
  output logic          q_push_o,
  output rbf_pkg::cmd_t cmd_o
);
  import rbf_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_WIDTH);

  logic [CNT_W-1:0]    col_q, col_d;
  logic [WID_W-1:0]    row_q, row_d;
  logic [RAD_W-1:0]    rad_q, rad_d;
  logic [RAD_W-1:0]    rad_clamp, row_rad;
  logic [WID_W:0]      eff_w;
  logic [WID_W-1:0]    eff_rows;
  logic [WID_W-1:0]    col_ext;
  logic                row_last, frame_last;

  assign pix_i.ready = !q_full_i;
  assign q_push_o    = pix_i.valid && !q_full_i;

  always_comb begin
    rad_clamp = (cfg_i.radius > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : cfg_i.radius;
    row_rad   = (col_q == '0) ? rad_clamp : rad_q;

    if (cfg_i.row_width == '0) begin
      eff_w = (WID_W+1)'(1);
    end else if ({1'b0, cfg_i.row_width} > (WID_W+1)'(MAX_WIDTH)) begin
      eff_w = (WID_W+1)'(MAX_WIDTH);
    end else begin
      eff_w = {1'b0, cfg_i.row_width};
    end
    eff_rows = (cfg_i.frame_rows == '0) ? WID_W'(1) : cfg_i.frame_rows;

    row_last   = ((WID_W+1)'(col_q) + (WID_W+1)'(1)) >= eff_w;
    frame_last = row_last && (({1'b0, row_q} + (WID_W+1)'(1)) >= {1'b0, eff_rows});

    col_ext = WID_W'(col_q);

    cmd_o.pixel      = pix_i.pixel;
    cmd_o.col_lo     = col_ext[COL_LO_W-1:0];
    cmd_o.col_sat    = (col_ext > WID_W'(COL_SAT_MAX)) ? COL_SAT_MAX
                                                       : col_ext[COL_LO_W-1:0];
    cmd_o.radius     = row_rad;
    cmd_o.row_last   = row_last;
    cmd_o.frame_last = frame_last;

    col_d = col_q;
    row_d = row_q;
    rad_d = rad_q;
    if (q_push_o) begin
      rad_d = row_rad;
      if (row_last) begin
        col_d = '0;
        row_d = frame_last ? '0 : row_q + WID_W'(1);
      end else begin
        col_d = col_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      rad_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      rad_q <= rad_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/rbf_queue.sv @@
// Short command queue between the front and back ends of the row box filter.
// Uses rbf_pkg for the command type and depth.
`default_nettype none

module rbf_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  rbf_pkg::cmd_t data_i,
  input  logic          pop_i,
  output rbf_pkg::cmd_t data_o,
  output logic          full_o,
  output logic          empty_o
);
  import rbf_pkg::*;

  cmd_t                mem_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wptr_q, wptr_d;
  logic [QUEUE_AW-1:0] rptr_q, rptr_d;
  logic [QUEUE_AW:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = push_i ? wptr_q + QUEUE_AW'(1) : wptr_q;
    rptr_d = pop_i  ? rptr_q + QUEUE_AW'(1) : rptr_q;
    cnt_d  = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + (QUEUE_AW+1)'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - (QUEUE_AW+1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/rbf_back.sv @@
// Back end of the row box filter: pixel ring memory, running window sum,
// end-of-row flush sequencer, reciprocal divide and output register.
// Uses rbf_pkg and rbf_res_if.
`default_nettype none

module rbf_back #(
  parameter int unsigned MAX_RADIUS = 31
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_empty_i,
  input  rbf_pkg::cmd_t q_head_i,
  output logic          q_pop_o,
  rbf_res_if.source     res_o
);
  import rbf_pkg::*;

  localparam int unsigned RING_D  = 2 ** $clog2(2 * MAX_RADIUS + 2);
  localparam int unsigned RING_AW = $clog2(RING_D);
  localparam int unsigned PROD_W  = SUM_W + RCP_W;

  logic [PIX_W-1:0]    ring_q [RING_D];
  logic [PIX_W-1:0]    rd_q;
  logic                rd_en;
  logic [COL_LO_W-1:0] rd_addr;

  back_state_e         state_q, state_d;
  cmd_t                cmd_q;
  logic [SUM_W-1:0]    sum_q, sum_d;
  logic [PIX_W-1:0]    first_q, first_d;
  logic [RAD_W-1:0]    dist_q, dist_d;
  logic                fin_q, fin_d;
  logic [PROD_W-1:0]   prod_q;

  logic                out_valid_q, out_valid_d;
  logic [PIX_W-1:0]    res_blurred_q;
  logic                res_row_end_q, res_frame_end_q, res_last_q;

  logic                out_load, more_flush;
  logic [COL_LO_W-1:0] r6, d1, dist6, dist_m1;
  logic [SUM_W-1:0]    init_sum;
  logic [PIX_W-1:0]    leave_sum, leave_fl;

  always_comb begin
    r6       = {1'b0, cmd_q.radius};
    d1       = {cmd_q.radius, 1'b1};
    dist6    = {1'b0, dist_q};
    dist_m1  = dist6 - COL_LO_W'(1);
    init_sum = SUM_W'(d1) * SUM_W'(cmd_q.pixel);

    // Pixels left of column zero read as the row's first pixel.
    leave_sum = (cmd_q.col_sat < d1) ? first_q : rd_q;
    leave_fl  = (cmd_q.col_sat < (dist6 + r6)) ? first_q : rd_q;

    out_load   = (state_q == BK_OUT) && (!out_valid_q || res_o.ready);
    more_flush = cmd_q.row_last && (dist_q != '0);
    q_pop_o    = !q_empty_i && ((state_q == BK_IDLE) || (out_load && !more_flush));

    rd_en = q_pop_o || (state_q == BK_FL_RD);
    if (q_pop_o) begin
      rd_addr = q_head_i.col_lo - {q_head_i.radius, 1'b1};
    end else begin
      rd_addr = cmd_q.col_lo - dist6 - r6;
    end
  end

  always_comb begin
    state_d = state_q;
    sum_d   = sum_q;
    first_d = first_q;
    dist_d  = dist_q;
    fin_d   = fin_q;
    case (state_q)
      BK_IDLE: begin
        if (q_pop_o) begin
          state_d = BK_SUM;
        end
      end
      BK_SUM: begin
        if (cmd_q.col_sat == '0) begin
          sum_d   = init_sum;
          first_d = cmd_q.pixel;
        end else begin
          sum_d = sum_q + SUM_W'(cmd_q.pixel) - SUM_W'(leave_sum);
        end
        if (cmd_q.row_last) begin
          dist_d = cmd_q.radius;
          if (cmd_q.col_sat >= r6) begin
            fin_d   = (cmd_q.radius == '0);
            state_d = BK_MUL;
          end else begin
            state_d = BK_FL_RD;
          end
        end else if (cmd_q.col_sat >= r6) begin
          fin_d   = 1'b1;
          state_d = BK_MUL;
        end else begin
          state_d = BK_IDLE;
        end
      end
      BK_FL_RD: begin
        state_d = BK_FL_UPD;
      end
      BK_FL_UPD: begin
        // Window moves one column right; the right edge clamps to the last pixel.
        sum_d  = sum_q + SUM_W'(cmd_q.pixel) - SUM_W'(leave_fl);
        dist_d = dist_q - RAD_W'(1);
        if (cmd_q.col_sat >= dist_m1) begin
          fin_d   = (dist_m1 == '0);
          state_d = BK_MUL;
        end else begin
          state_d = BK_FL_RD;
        end
      end
      BK_MUL: begin
        state_d = BK_OUT;
      end
      BK_OUT: begin
        if (out_load) begin
          if (more_flush) begin
            state_d = BK_FL_RD;
          end else if (q_pop_o) begin
            state_d = BK_SUM;
          end else begin
            state_d = BK_IDLE;
          end
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      ring_q[q_head_i.col_lo[RING_AW-1:0]] <= q_head_i.pixel;
    end
    if (rd_en) begin
      rd_q <= ring_q[rd_addr[RING_AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cmd_q <= q_head_i;
    end
    sum_q   <= sum_d;
    first_q <= first_d;
    dist_q  <= dist_d;
    fin_q   <= fin_d;
    if (state_q == BK_MUL) begin
      prod_q <= PROD_W'(sum_q + SUM_W'(cmd_q.radius)) * PROD_W'(recip(cmd_q.radius));
    end
    if (out_load) begin
      res_blurred_q   <= prod_q[RCP_SHIFT +: PIX_W];
      res_last_q      <= fin_q;
      res_row_end_q   <= fin_q && cmd_q.row_last;
      res_frame_end_q <= fin_q && cmd_q.frame_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign res_o.valid     = out_valid_q;
  assign res_o.blurred   = res_blurred_q;
  assign res_o.row_end   = res_row_end_q;
  assign res_o.frame_end = res_frame_end_q;
  assign res_o.last      = res_last_q;

  a_frame_end_closes_row : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_frame_end_q |-> res_row_end_q && res_last_q)
    else $error("frame end without row end and last");

  a_flush_only_on_row_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_FL_RD || state_q == BK_FL_UPD) |-> cmd_q.row_last)
    else $error("flush sequencer running outside a row end");

  a_flush_distance : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_FL_RD || state_q == BK_FL_UPD) |->
      (dist_q != '0) && (dist_q <= cmd_q.radius))
    else $error("flush distance out of range");

  a_ring_no_collision : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> rd_addr[RING_AW-1:0] != q_head_i.col_lo[RING_AW-1:0])
    else $error("ring read and write collide");

endmodule

`default_nettype wire

@@ rtl/row_box_filter_clamped.sv @@
// Horizontal box filter with clamped row edges: top level with the
// configuration registers. Uses rbf_pkg, rbf_pix_if, rbf_res_if and the
// rbf_front, rbf_queue and rbf_back modules.
//
// Usage: grey 8-bit pixels enter in raster order on pix_i (valid/ready).
// Each row is filtered on its own; result items leave on res_o
// (valid/ready) carrying the rounded mean of the 2r+1 pixels around one
// column, with row_end, frame_end and last flags. Output j of a row leaves
// after pixel j+r; the row's last pixel flushes the remaining outputs.
// The configuration port (cfg_we_i, cfg_idx_i, cfg_data_i) writes radius,
// row width and frame rows; write it only while the block is idle.
// The back end sequencer takes one pixel at a time: it updates the window
// sum and, at column r or beyond, multiplies by the reciprocal and loads the
// output register, popping the next pixel as it loads. A row's last pixel
// flushes each further output by a ring read and sum update, then multiply
// and load; a last pixel below column r runs such steps before its first
// output. A four-entry command queue lets pixels be accepted while the back
// end works or its output register is stalled; pix_i.ready drops only when
// that queue is full. Reset restores the register defaults and restarts at
// row 0, column 0; the pixel ring needs no clearing.
`default_nettype none

module row_box_filter_clamped #(
  parameter int unsigned MAX_RADIUS = 31,
  parameter int unsigned MAX_WIDTH  = 4096
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  rbf_pix_if.sink                       pix_i,
  rbf_res_if.source                     res_o,
  input  logic                          cfg_we_i,
  input  logic [rbf_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [rbf_pkg::WID_W-1:0]     cfg_data_i
);
  import rbf_pkg::*;

  cfg_t cfg_q, cfg_d;
  cmd_t push_cmd, head_cmd;
  logic push, pop, full, empty;

  // Register writes; an index beyond the list is ignored.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_RADIUS:     cfg_d.radius     = cfg_data_i[RAD_W-1:0];
        CFG_ROW_WIDTH:  cfg_d.row_width  = cfg_data_i;
        CFG_FRAME_ROWS: cfg_d.frame_rows = cfg_data_i;
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.radius     <= RADIUS_RESET;
      cfg_q.row_width  <= ROW_WIDTH_RESET;
      cfg_q.frame_rows <= FRAME_ROWS_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // The front end classifies each pixel by column and row position.
  rbf_front #(
    .MAX_RADIUS (MAX_RADIUS),
    .MAX_WIDTH  (MAX_WIDTH)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .pix_i    (pix_i),
    .q_full_i (full),
    .q_push_o (push),
    .cmd_o    (push_cmd)
  );

  rbf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_cmd),
    .pop_i   (pop),
    .data_o  (head_cmd),
    .full_o  (full),
    .empty_o (empty)
  );

  // The back end keeps the window sum and produces the result items.
  rbf_back #(
    .MAX_RADIUS (MAX_RADIUS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (empty),
    .q_head_i  (head_cmd),
    .q_pop_o   (pop),
    .res_o     (res_o)
  );

endmodule

`default_nettype wire

@@ verif/rbf_checker.sv @@
`timescale 1ns / 100ps
// Result checker for the clamped row box filter: watches the pixel, result and
// register channels, predicts every result item and compares it field by field.
// Depends on rbf_pkg and the rbf_pix_if and rbf_res_if interfaces.

module rbf_checker #(
  parameter int unsigned MAX_RADIUS = 31,
  parameter int unsigned MAX_WIDTH  = 4096
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  rbf_pix_if                            pix_mon_i,
  rbf_res_if                            res_mon_i,
  input  logic                          cfg_we_i,
  input  logic [rbf_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [rbf_pkg::WID_W-1:0]     cfg_data_i,
  output int                            fail_count_o,
  output int                            pending_o,
  output int                            pixels_o,
  output int                            results_o
);
  import rbf_pkg::*;

  typedef struct packed {
    logic [PIX_W-1:0] blurred;
    logic             row_end;
    logic             frame_end;
    logic             last;
  } blur_item_t;

  blur_item_t blur_expect_q[$];

  // Shadow copy of the registers and of the filter state.
  logic [RAD_W-1:0] reg_radius;
  logic [WID_W-1:0] reg_width;
  logic [WID_W-1:0] reg_rows;
  logic [PIX_W-1:0] recent_pix [64];
  logic [PIX_W-1:0] row_first;
  logic [WID_W-1:0] col_cnt;
  logic [WID_W-1:0] row_cnt;
  logic [RAD_W-1:0] row_radius;
  int               fail_total;

  // Window sum for output column j; column c is the newest pixel and the
  // right clamp bound, columns below zero read the row's first pixel.
  function automatic int clamped_sum(input int j, input int c, input int r);
    int s;
    int k;
    s = 0;
    for (k = j - r; k <= j + r; k++) begin
      if (k < 0) s += row_first;
      else if (k > c) s += recent_pix[c & 63];
      else s += recent_pix[k & 63];
    end
    return s & 16'h3FFF;
  endfunction

  task automatic predict_pixel(input logic [PIX_W-1:0] px);
    int         w;
    int         fr;
    int         c;
    int         r;
    int         j;
    int         jlo;
    int         jhi;
    int         sum;
    bit         row_last;
    bit         frame_last;
    blur_item_t item;
    w = (reg_width == 0) ? 1 : int'(reg_width);
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    fr = (reg_rows == 0) ? 1 : int'(reg_rows);
    c = int'(col_cnt);
    if (col_cnt == 0) begin
      row_radius = (reg_radius > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : reg_radius;
      row_first = px;
    end
    r = int'(row_radius);
    recent_pix[col_cnt[5:0]] = px;
    row_last = (c + 1 >= w);
    frame_last = row_last && (int'(row_cnt) + 1 >= fr);
    jlo = c - r;
    if (row_last) begin
      if (jlo < 0) jlo = 0;
      jhi = c;
    end else begin
      jhi = jlo;
    end
    for (j = jlo; j <= jhi && j >= 0; j++) begin
      sum = clamped_sum(j, c, r);
      item.blurred   = PIX_W'((sum + r) / (2 * r + 1));
      item.row_end   = row_last && (j == jhi);
      item.frame_end = frame_last && (j == jhi);
      item.last      = (j == jhi);
      blur_expect_q.push_back(item);
    end
    if (row_last) begin
      col_cnt = '0;
      row_cnt = frame_last ? '0 : row_cnt + 1'b1;
    end else begin
      col_cnt = col_cnt + 1'b1;
    end
  endtask

  function automatic void check_field(input string name, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_val, act_val);
      fail_total++;
    end
  endfunction

  task automatic check_result();
    blur_item_t item;
    if (blur_expect_q.size() == 0) begin
      $error("result item with none expected: blurred %0d", res_mon_i.blurred);
      fail_total++;
    end else begin
      item = blur_expect_q.pop_front();
      check_field("blurred", item.blurred, res_mon_i.blurred);
      check_field("row_end", item.row_end, res_mon_i.row_end);
      check_field("frame_end", item.frame_end, res_mon_i.frame_end);
      check_field("last", item.last, res_mon_i.last);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reg_radius = RADIUS_RESET;
      reg_width  = ROW_WIDTH_RESET;
      reg_rows   = FRAME_ROWS_RESET;
      row_first  = '0;
      col_cnt    = '0;
      row_cnt    = '0;
      row_radius = '0;
      fail_total = 0;
      foreach (recent_pix[i]) recent_pix[i] = '0;
      blur_expect_q.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
      pixels_o     <= 0;
      results_o    <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_RADIUS:     reg_radius = cfg_data_i[RAD_W-1:0];
          CFG_ROW_WIDTH:  reg_width  = cfg_data_i;
          CFG_FRAME_ROWS: reg_rows   = cfg_data_i;
          default: ;
        endcase
      end
      if (res_mon_i.valid && res_mon_i.ready) begin
        check_result();
        results_o <= results_o + 1;
      end
      if (pix_mon_i.valid && pix_mon_i.ready) begin
        predict_pixel(pix_mon_i.pixel);
        pixels_o <= pixels_o + 1;
      end
      pending_o    <= blur_expect_q.size();
      fail_count_o <= fail_total;
    end
  end

endmodule

@@ verif/tb_row_box_filter_clamped.sv @@
`timescale 1ns / 100ps
// Testbench top for the clamped row box filter: clock, reset, pixel and
// register stimulus, receiver stalls, watchdog and verdict.
// Depends on rbf_pkg, the channel interfaces, the block and rbf_checker.

module tb_row_box_filter_clamped;
  import rbf_pkg::*;

  localparam int unsigned MAX_RADIUS = 31;
  localparam int unsigned MAX_WIDTH  = 4096;

  // Random pixel items to send after the directed part.
  localparam int RANDOM_PIXELS  = 370;
  // Length of the deliberate receiver hold-off that backs the block up.
  localparam int LONG_HOLD      = 150;
  // Cycles to let pass after the last expected result before touching the
  // registers; covers pixels still queued that produce no result.
  localparam int SETTLE_CYCLES  = 40;
  // Cycles with no item moving on any channel before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 2000;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [WID_W-1:0]     cfg_data;

  rbf_pix_if pix_ch();
  rbf_res_if res_ch();

  int fail_count;
  int pending;
  int pixels_seen;
  int results_seen;
  int idle_cycles = 0;
  int hold_requests = 0;
  int holds_served = 0;
  int settings_used = 0;
  // When set, neither side inserts gaps.
  bit calm = 1'b0;
  // Set while the block is known to sit at the start of a row.
  bit aligned;

  row_box_filter_clamped #(
    .MAX_RADIUS(MAX_RADIUS),
    .MAX_WIDTH (MAX_WIDTH)
  ) dut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .pix_i     (pix_ch),
    .res_o     (res_ch),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data)
  );

  rbf_checker #(
    .MAX_RADIUS(MAX_RADIUS),
    .MAX_WIDTH (MAX_WIDTH)
  ) u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .pix_mon_i   (pix_ch),
    .res_mon_i   (res_ch),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .pixels_o    (pixels_seen),
    .results_o   (results_seen)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap();
    int roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Flat pixels at both extremes show up often so that window sums reach
  // their maximum and the rounding is tried at zero.
  function automatic logic [PIX_W-1:0] rand_pixel();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 15) return '0;
    if (roll < 30) return '1;
    return PIX_W'($urandom_range(0, 255));
  endfunction

  // The block clamps a zero width to one and a huge width to MAX_WIDTH.
  function automatic int eff_width(input int v);
    if (v == 0) return 1;
    if (v > MAX_WIDTH) return MAX_WIDTH;
    return v;
  endfunction

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [WID_W-1:0] data);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  task automatic use_regs(input logic [WID_W-1:0] rad_data, input logic [WID_W-1:0] width,
                          input logic [WID_W-1:0] rows);
    cfg_write(CFG_RADIUS, rad_data);
    cfg_write(CFG_ROW_WIDTH, width);
    cfg_write(CFG_FRAME_ROWS, rows);
    settings_used++;
  endtask

  // Offers one pixel item after a random gap and returns at the edge where it
  // is taken. Valid stays high into the next item when there is no gap.
  task automatic send_pixel(input logic [PIX_W-1:0] px);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      pix_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_ch.valid <= 1'b1;
    pix_ch.pixel <= px;
    @(posedge clk);
    while (!pix_ch.ready) @(posedge clk);
  endtask

  // Waits until every predicted result has come out, then gives pixels still
  // queued inside the block (which cause no result) time to drain.
  task automatic drain();
    pix_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Receiver: random ready gaps, plus a long hold-off whenever the stimulus
  // asks for one, counted here so the sender keeps pushing meanwhile.
  initial begin : receiver
    int gap;
    res_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (holds_served != hold_requests) begin
        res_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        holds_served++;
      end else begin
        gap = pick_gap();
        if (gap == 0) begin
          res_ch.ready <= 1'b1;
          @(posedge clk);
        end else begin
          res_ch.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  // Any item moving on either channel, or a register write, counts as progress.
  always @(posedge clk) begin
    if (!rst_n || (pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready) || cfg_we)
    begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : watchdog
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("Watchdog: no item moved for %0d cycles, %0d results still expected",
             WATCHDOG_LIMIT, pending);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    int               n;
    int               k;
    int               w;
    int               r;
    int               roll;
    int               random_sent;
    int               phase_no;
    bit               clean;
    bit               pressure;
    logic [WID_W-1:0] width_val;
    logic [WID_W-1:0] rad_data;
    logic [WID_W-1:0] rows_val;

    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = CFG_RADIUS;
    cfg_data     = '0;
    pix_ch.valid = 1'b0;
    pix_ch.pixel = '0;
    random_sent  = 0;
    phase_no     = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Radius zero with one-pixel rows and one-row frames: every pixel is its
    // own result and closes both a row and a frame, at both pixel extremes.
    use_regs(13'd0, 13'd1, 13'd1);
    send_pixel(8'd0);
    send_pixel(8'd255);
    drain();

    // Largest radius (written with all data bits set) on rows of three, far
    // narrower than the window: each row's last pixel flushes three results.
    use_regs(13'h1FFF, 13'd3, 13'd2);
    send_pixel(8'd255);
    send_pixel(8'd255);
    send_pixel(8'd255);
    send_pixel(8'd0);
    send_pixel(8'd128);
    send_pixel(8'd255);
    drain();

    // Width above the maximum, zero frame rows; the row is left open.
    use_regs(13'd2, 13'h1FFF, 13'd0);
    send_pixel(8'd255);
    send_pixel(8'd0);
    send_pixel(8'd255);
    send_pixel(8'd0);
    send_pixel(8'd255);
    drain();

    // Width lowered below the current column: the next pixel ends the row
    // with the old radius. The new radius applies from the following row.
    cfg_write(CFG_ROW_WIDTH, 13'd3);
    cfg_write(CFG_RADIUS, 13'd5);
    settings_used++;
    send_pixel(8'd17);
    send_pixel(8'd1);
    send_pixel(8'd2);
    send_pixel(8'd3);
    drain();

    // A tall frame, then its row count lowered mid-frame together with a
    // zero width, so the next pixel ends both the row and the frame.
    use_regs(13'd0, 13'd2, 13'd4096);
    send_pixel(8'd10);
    send_pixel(8'd20);
    send_pixel(8'd30);
    send_pixel(8'd40);
    drain();
    cfg_write(CFG_FRAME_ROWS, 13'd1);
    cfg_write(CFG_ROW_WIDTH, 13'd0);
    settings_used++;
    send_pixel(8'd50);
    send_pixel(8'd60);
    drain();
    aligned = 1'b1;

    // Random phases. Most send whole rows from a row start; the rest change
    // registers in the middle of a row and send a ragged number of pixels.
    while (random_sent < RANDOM_PIXELS) begin
      phase_no++;
      pressure = (phase_no == 3 || phase_no == 15);
      clean = pressure || ($urandom_range(0, 99) < 80);
      calm = pressure || ($urandom_range(0, 4) == 0);

      // Bring a ragged row to its end: a width of one (or zero) makes the
      // very next pixel close the row, whatever its column.
      if (clean && !aligned) begin
        cfg_write(CFG_ROW_WIDTH, WID_W'($urandom_range(0, 1)));
        send_pixel(rand_pixel());
        random_sent++;
        drain();
      end

      roll = $urandom_range(0, 99);
      if (roll < 20) r = 0;
      else if (roll < 40) r = 31;
      else r = $urandom_range(1, 30);
      rad_data = {PIX_W'($urandom_range(0, 255)), RAD_W'(r)};

      roll = $urandom_range(0, 99);
      if (roll < 10) rows_val = '0;
      else if (roll < 20) rows_val = WID_W'($urandom_range(4096, 8191));
      else rows_val = WID_W'($urandom_range(1, 4));

      if (clean) begin
        roll = $urandom_range(0, 99);
        k = $urandom_range(1, 3);
        if (pressure) begin
          width_val = 13'd8;
          k = 3;
        end else if (roll < 70) begin
          width_val = WID_W'($urandom_range(1, 12));
        end else if (roll < 88) begin
          width_val = WID_W'($urandom_range(13, 24));
        end else begin
          // Rows from the pixel ring's length upward, so its index can wrap.
          width_val = WID_W'($urandom_range(64, 72));
          k = 1;
        end
        if ($urandom_range(0, 99) < 70) cfg_write(CFG_RADIUS, rad_data);
        cfg_write(CFG_ROW_WIDTH, width_val);
        if ($urandom_range(0, 1) == 1) cfg_write(CFG_FRAME_ROWS, rows_val);
        w = eff_width(int'(width_val));
        n = w * k;
        aligned = 1'b1;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 15) width_val = '0;
        else if (roll < 30) width_val = WID_W'($urandom_range(4097, 8191));
        else width_val = WID_W'($urandom_range(1, 30));
        if ($urandom_range(0, 99) < 60) cfg_write(CFG_RADIUS, rad_data);
        if ($urandom_range(0, 99) < 60) cfg_write(CFG_ROW_WIDTH, width_val);
        if ($urandom_range(0, 99) < 60) cfg_write(CFG_FRAME_ROWS, rows_val);
        n = $urandom_range(1, 30);
        aligned = 1'b0;
      end
      settings_used++;

      // The receiver stops for a long stretch while pixels keep coming.
      if (pressure) hold_requests++;
      repeat (n) send_pixel(rand_pixel());
      random_sent += n;
      drain();
    end

    $display("Run covered %0d pixel items and %0d result items over %0d register settings,",
             pixels_seen, results_seen, settings_used);
    $display("with radius 0 to 31, short, wide and clamped rows, and mid-row register changes.");
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
